FILE: design/cpid_pkg.sv
`timescale 1ns / 1ps
// shared widths, register indexes, multiplier selects and control structs for the pid core
package cpid_pkg;

  localparam int ERR_W      = 16;
  localparam int MAG_W      = 16;
  localparam int DE_W       = ERR_W + 1;
  localparam int EL_W       = 20;
  localparam int ACC_W      = 48;
  localparam int V_W        = ACC_W + 1;
  localparam int KP_W       = 32;
  localparam int KI_W       = 32;
  localparam int KD_W       = 48;
  localparam int ILIM_W     = 47;
  localparam int OLIM_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int SUM_W      = 50;

  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 24;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int W_W        = PROD_W + 1;

  localparam int FRAC_SH    = 16;
  localparam int SPLIT      = 24;
  localparam int I_SH       = 40;
  localparam int HI_KEEP_W  = I_SH - SPLIT;
  localparam int IQ_W       = PROD_W - HI_KEEP_W + 1;
  localparam int ED_W       = MAG_W + EL_W;
  localparam int DPROD_W    = SPLIT + MAG_W;
  localparam int DHI_SH     = SPLIT - FRAC_SH;

  localparam int DIV_N_W        = 48;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = DIV_N_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  localparam logic [EL_W-1:0] DT_LIMIT_RST = EL_W'(500000);

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DT_LIMIT       = CFG_IDX_W'(5);

  typedef enum logic [2:0] {
    MUL_P,
    MUL_ED,
    MUL_ILO,
    MUL_IHI,
    MUL_DLO,
    MUL_DHI
  } cpid_mul_e;

  typedef struct packed {
    logic      load_in;
    logic      sum_clr;
    logic      clr_state;
    logic      run_setup;
    logic      mul_en;
    cpid_mul_e mul_sel;
    logic      p_add;
    logic      i_sum;
    logic      i_clamp;
    logic      w_keep;
    logic      i_low;
    logic      i_quot;
    logic      i_add;
    logic      d_start;
    logic      d_add;
    logic      out_load;
  } cpid_cmd_t;

  typedef struct packed {
    logic cmd_reset;
    logic olim_zero;
    logic dt_nz;
    logic integ_go;
    logic div_done;
  } cpid_stat_t;

endpackage

FILE: design/cpid_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, two quotient bits per cycle
module cpid_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [cpid_pkg::DIV_N_W-1:0]     dividend_i,
  input  logic [cpid_pkg::EL_W-1:0]        divisor_i,
  output logic                             done_o,
  output logic [cpid_pkg::DIV_N_W-1:0]     quotient_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [cpid_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [cpid_pkg::EL_W-1:0]       rem_q, rem_d;
  logic [cpid_pkg::DIV_N_W-1:0]    quo_q, quo_d;
  logic [cpid_pkg::EL_W:0]         trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int k = 0; k < cpid_pkg::DIV_RADIX_BITS; k++) begin
      trial = {rem_d, quo_d[cpid_pkg::DIV_N_W-1]};
      quo_d = {quo_d[cpid_pkg::DIV_N_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial    = trial - {1'b0, divisor_i};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[cpid_pkg::EL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == cpid_pkg::DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/cpid_dp.sv
`timescale 1ns / 1ps
// pid datapath: config registers, controller state, shared multiplier, divider, output register
module cpid_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   cmd_i,
  input  logic signed [cpid_pkg::ERR_W-1:0]      error_i,
  input  logic [cpid_pkg::EL_W-1:0]              elapsed_us_i,
  input  cpid_pkg::cpid_cmd_t                    ctl_i,
  output cpid_pkg::cpid_stat_t                   stat_o,
  output logic signed [cpid_pkg::ERR_W-1:0]      drive_o,
  output logic                                   saturated_o
);

  // configuration, gains kept as magnitude and sign
  logic [cpid_pkg::KP_W-1:0]   kp_mag_q;
  logic                        kp_neg_q;
  logic [cpid_pkg::KI_W-1:0]   ki_mag_q;
  logic                        ki_neg_q;
  logic [cpid_pkg::KD_W-1:0]   kd_mag_q;
  logic                        kd_neg_q;
  logic [cpid_pkg::ILIM_W-1:0] ilim_q;
  logic [cpid_pkg::OLIM_W-1:0] olim_q;
  logic [cpid_pkg::EL_W-1:0]   dtlim_q;

  logic [cpid_pkg::KP_W-1:0]   cfg_kp_mag;
  logic [cpid_pkg::KI_W-1:0]   cfg_ki_mag;
  logic [cpid_pkg::KD_W-1:0]   cfg_kd_mag;

  // controller state
  logic                        started_q;
  logic [cpid_pkg::ACC_W-1:0]  acc_q;
  logic [cpid_pkg::ILIM_W-1:0] acc_mag_q;
  logic [cpid_pkg::ERR_W-1:0]  last_err_q;

  // per item working registers
  logic                        cmd_q;
  logic [cpid_pkg::ERR_W-1:0]  err_q;
  logic [cpid_pkg::EL_W-1:0]   el_q;
  logic [cpid_pkg::EL_W-1:0]   dt_q;
  logic [cpid_pkg::MAG_W-1:0]  err_mag_q;
  logic                        err_neg_q;
  logic [cpid_pkg::MAG_W-1:0]  de_mag_q;
  logic                        de_neg_q;
  logic [cpid_pkg::PROD_W-1:0] prod_q;
  logic [cpid_pkg::W_W-1:0]    w_q;
  logic [cpid_pkg::V_W-1:0]    v_q;
  logic [cpid_pkg::SUM_W-1:0]  sum_q;
  logic [cpid_pkg::ERR_W-1:0]  drive_q;
  logic                        sat_q;

  logic [cpid_pkg::MAG_W-1:0]   err_mag;
  logic [cpid_pkg::DE_W-1:0]    de;
  logic [cpid_pkg::MAG_W-1:0]   de_mag;
  logic                         dt_ok;
  logic [cpid_pkg::MUL_A_W-1:0] mul_a;
  logic [cpid_pkg::MUL_B_W-1:0] mul_b;
  logic [cpid_pkg::SUM_W-1:0]   add_mag;
  logic                         add_neg;
  logic [cpid_pkg::SUM_W-1:0]   sum_d;
  logic [cpid_pkg::V_W-1:0]     ed_term;
  logic [cpid_pkg::V_W-1:0]     acc_ext;
  logic [cpid_pkg::V_W-1:0]     ilim_pos;
  logic [cpid_pkg::V_W-1:0]     ilim_neg;
  logic [cpid_pkg::V_W-1:0]     v_mag;
  logic [cpid_pkg::W_W-1:0]     low_add;
  logic [cpid_pkg::W_W-1:0]     q_hi;
  logic [cpid_pkg::W_W-1:0]     q_lo;
  logic [cpid_pkg::DIV_N_W-1:0] div_hi;
  logic [cpid_pkg::DIV_N_W-1:0] div_lo;
  logic [cpid_pkg::DIV_N_W-1:0] quotient;
  logic                         div_done;
  logic [cpid_pkg::SUM_W-1:0]   olim_pos;
  logic [cpid_pkg::SUM_W-1:0]   olim_neg;

  assign cfg_kp_mag = cfg_data_i[cpid_pkg::KP_W-1] ?
                      (~cfg_data_i[cpid_pkg::KP_W-1:0] + 1'b1) : cfg_data_i[cpid_pkg::KP_W-1:0];
  assign cfg_ki_mag = cfg_data_i[cpid_pkg::KI_W-1] ?
                      (~cfg_data_i[cpid_pkg::KI_W-1:0] + 1'b1) : cfg_data_i[cpid_pkg::KI_W-1:0];
  assign cfg_kd_mag = cfg_data_i[cpid_pkg::KD_W-1] ?
                      (~cfg_data_i[cpid_pkg::KD_W-1:0] + 1'b1) : cfg_data_i[cpid_pkg::KD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_mag_q <= '0;
      kp_neg_q <= 1'b0;
      ki_mag_q <= '0;
      ki_neg_q <= 1'b0;
      kd_mag_q <= '0;
      kd_neg_q <= 1'b0;
      ilim_q   <= '0;
      olim_q   <= '0;
      dtlim_q  <= cpid_pkg::DT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpid_pkg::REG_PROP_GAIN: begin
          kp_mag_q <= cfg_kp_mag;
          kp_neg_q <= cfg_data_i[cpid_pkg::KP_W-1];
        end
        cpid_pkg::REG_INTEG_GAIN: begin
          ki_mag_q <= cfg_ki_mag;
          ki_neg_q <= cfg_data_i[cpid_pkg::KI_W-1];
        end
        cpid_pkg::REG_DERIV_GAIN: begin
          kd_mag_q <= cfg_kd_mag;
          kd_neg_q <= cfg_data_i[cpid_pkg::KD_W-1];
        end
        cpid_pkg::REG_INTEGRAL_LIMIT: ilim_q  <= cfg_data_i[cpid_pkg::ILIM_W-1:0];
        cpid_pkg::REG_OUTPUT_LIMIT:   olim_q  <= cfg_data_i[cpid_pkg::OLIM_W-1:0];
        cpid_pkg::REG_DT_LIMIT:       dtlim_q <= cfg_data_i[cpid_pkg::EL_W-1:0];
        default: ;
      endcase
    end
  end

  // item setup
  assign err_mag = err_q[cpid_pkg::ERR_W-1] ? (~err_q + 1'b1) : err_q;
  assign de      = {err_q[cpid_pkg::ERR_W-1], err_q} - {last_err_q[cpid_pkg::ERR_W-1], last_err_q};
  assign de_mag  = de[cpid_pkg::DE_W-1] ? (~de[cpid_pkg::MAG_W-1:0] + 1'b1) :
                                          de[cpid_pkg::MAG_W-1:0];
  assign dt_ok   = started_q && (el_q != '0) && (el_q <= dtlim_q);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl_i.mul_sel)
      cpid_pkg::MUL_P: begin
        mul_a                        = kp_mag_q;
        mul_b[cpid_pkg::MAG_W-1:0]   = err_mag_q;
      end
      cpid_pkg::MUL_ED: begin
        mul_a[cpid_pkg::MAG_W-1:0]   = err_mag_q;
        mul_b[cpid_pkg::EL_W-1:0]    = dt_q;
      end
      cpid_pkg::MUL_ILO: begin
        mul_a                        = ki_mag_q;
        mul_b                        = acc_mag_q[cpid_pkg::SPLIT-1:0];
      end
      cpid_pkg::MUL_IHI: begin
        mul_a                                        = ki_mag_q;
        mul_b[cpid_pkg::ILIM_W-cpid_pkg::SPLIT-1:0]  = acc_mag_q[cpid_pkg::ILIM_W-1:cpid_pkg::SPLIT];
      end
      cpid_pkg::MUL_DLO: begin
        mul_a[cpid_pkg::SPLIT-1:0]   = kd_mag_q[cpid_pkg::SPLIT-1:0];
        mul_b[cpid_pkg::MAG_W-1:0]   = de_mag_q;
      end
      cpid_pkg::MUL_DHI: begin
        mul_a[cpid_pkg::KD_W-cpid_pkg::SPLIT-1:0] = kd_mag_q[cpid_pkg::KD_W-1:cpid_pkg::SPLIT];
        mul_b[cpid_pkg::MAG_W-1:0]                = de_mag_q;
      end
      default: ;
    endcase
  end

  // term accumulation into the sum
  always_comb begin
    add_mag = '0;
    add_neg = 1'b0;
    if (ctl_i.p_add) begin
      add_mag[cpid_pkg::KP_W-1:0] = prod_q[cpid_pkg::FRAC_SH +: cpid_pkg::KP_W];
      add_neg                     = kp_neg_q ^ err_neg_q;
    end else if (ctl_i.i_add) begin
      add_mag[cpid_pkg::IQ_W-1:0] = w_q[cpid_pkg::IQ_W-1:0];
      add_neg                     = ki_neg_q ^ acc_q[cpid_pkg::ACC_W-1];
    end else if (ctl_i.d_add) begin
      add_mag[cpid_pkg::DIV_N_W-1:0] = quotient;
      add_neg                        = kd_neg_q ^ de_neg_q;
    end
  end

  assign sum_d = add_neg ? (sum_q - add_mag) : (sum_q + add_mag);

  // integral update
  always_comb begin
    ed_term = '0;
    ed_term[cpid_pkg::ED_W-1:0] = prod_q[cpid_pkg::ED_W-1:0];
    acc_ext = {acc_q[cpid_pkg::ACC_W-1], acc_q};
    ilim_pos = '0;
    ilim_pos[cpid_pkg::ILIM_W-1:0] = ilim_q;
  end

  assign ilim_neg = ~ilim_pos + 1'b1;
  assign v_mag    = v_q[cpid_pkg::V_W-1] ? (~v_q + 1'b1) : v_q;

  // integral term partial product combine
  always_comb begin
    low_add = '0;
    low_add[cpid_pkg::SPLIT +: cpid_pkg::HI_KEEP_W] = prod_q[cpid_pkg::HI_KEEP_W-1:0];
    q_hi = '0;
    q_hi[cpid_pkg::PROD_W-cpid_pkg::HI_KEEP_W-1:0] =
      prod_q[cpid_pkg::PROD_W-1:cpid_pkg::HI_KEEP_W];
    q_lo = '0;
    q_lo[cpid_pkg::W_W-cpid_pkg::I_SH-1:0] = w_q[cpid_pkg::W_W-1:cpid_pkg::I_SH];
  end

  // derivative dividend, product shifted down by 16
  always_comb begin
    div_hi = '0;
    div_hi[cpid_pkg::DIV_N_W-1:cpid_pkg::DHI_SH] =
      prod_q[cpid_pkg::DIV_N_W-cpid_pkg::DHI_SH-1:0];
    div_lo = '0;
    div_lo[cpid_pkg::DPROD_W-cpid_pkg::FRAC_SH-1:0] =
      w_q[cpid_pkg::DPROD_W-1:cpid_pkg::FRAC_SH];
  end

  cpid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.d_start),
    .dividend_i (div_hi + div_lo),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    olim_pos = '0;
    olim_pos[cpid_pkg::OLIM_W-1:0] = olim_q;
  end

  assign olim_neg = ~olim_pos + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      acc_q      <= '0;
      acc_mag_q  <= '0;
      last_err_q <= '0;
    end else if (ctl_i.clr_state) begin
      started_q  <= 1'b0;
      acc_q      <= '0;
      acc_mag_q  <= '0;
      last_err_q <= '0;
    end else if (ctl_i.run_setup) begin
      started_q  <= 1'b1;
      last_err_q <= err_q;
    end else if (ctl_i.i_clamp) begin
      if ($signed(v_q) > $signed(ilim_pos)) begin
        acc_q     <= ilim_pos[cpid_pkg::ACC_W-1:0];
        acc_mag_q <= ilim_q;
      end else if ($signed(v_q) < $signed(ilim_neg)) begin
        acc_q     <= ilim_neg[cpid_pkg::ACC_W-1:0];
        acc_mag_q <= ilim_q;
      end else begin
        acc_q     <= v_q[cpid_pkg::ACC_W-1:0];
        acc_mag_q <= v_mag[cpid_pkg::ILIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q <= cmd_i;
      err_q <= error_i;
      el_q  <= elapsed_us_i;
    end
    if (ctl_i.run_setup) begin
      dt_q      <= dt_ok ? el_q : '0;
      err_mag_q <= err_mag;
      err_neg_q <= err_q[cpid_pkg::ERR_W-1];
      de_mag_q  <= de_mag;
      de_neg_q  <= de[cpid_pkg::DE_W-1];
    end
    if (ctl_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (ctl_i.i_sum) begin
      v_q <= err_neg_q ? (acc_ext - ed_term) : (acc_ext + ed_term);
    end
    if (ctl_i.w_keep) begin
      w_q <= {1'b0, prod_q};
    end else if (ctl_i.i_low) begin
      w_q <= w_q + low_add;
    end else if (ctl_i.i_quot) begin
      w_q <= q_hi + q_lo;
    end
    if (ctl_i.sum_clr) begin
      sum_q <= '0;
    end else if (ctl_i.p_add || ctl_i.i_add || ctl_i.d_add) begin
      sum_q <= sum_d;
    end
    if (ctl_i.out_load) begin
      if ($signed(sum_q) > $signed(olim_pos)) begin
        drive_q <= olim_pos[cpid_pkg::ERR_W-1:0];
        sat_q   <= 1'b1;
      end else if ($signed(sum_q) < $signed(olim_neg)) begin
        drive_q <= olim_neg[cpid_pkg::ERR_W-1:0];
        sat_q   <= 1'b1;
      end else begin
        drive_q <= sum_q[cpid_pkg::ERR_W-1:0];
        sat_q   <= 1'b0;
      end
    end
  end

  assign stat_o.cmd_reset = cmd_q;
  assign stat_o.olim_zero = (olim_q == '0);
  assign stat_o.dt_nz     = (dt_q != '0);
  assign stat_o.integ_go  = (dt_q != '0) && (ki_mag_q != '0);
  assign stat_o.div_done  = div_done;

  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

endmodule

FILE: design/cpid_ctrl.sv
`timescale 1ns / 1ps
// pid sequencer: handshakes and the step order of the datapath
module cpid_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  cpid_pkg::cpid_stat_t  stat_i,
  output cpid_pkg::cpid_cmd_t   cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_PMUL   = 4'd2;
  localparam logic [3:0] ST_PADD   = 4'd3;
  localparam logic [3:0] ST_ISUM   = 4'd4;
  localparam logic [3:0] ST_ICLAMP = 4'd5;
  localparam logic [3:0] ST_ILO    = 4'd6;
  localparam logic [3:0] ST_IHI    = 4'd7;
  localparam logic [3:0] ST_ILOW   = 4'd8;
  localparam logic [3:0] ST_IQ     = 4'd9;
  localparam logic [3:0] ST_IACC   = 4'd10;
  localparam logic [3:0] ST_DHI    = 4'd11;
  localparam logic [3:0] ST_DDIV   = 4'd12;
  localparam logic [3:0] ST_DWAIT  = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.sum_clr = 1'b1;
        if (stat_i.cmd_reset) begin
          cmd_o.clr_state = 1'b1;
          state_d         = ST_OUT;
        end else if (stat_i.olim_zero) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.run_setup = 1'b1;
          state_d         = ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpid_pkg::MUL_P;
        state_d       = ST_PADD;
      end
      ST_PADD: begin
        cmd_o.p_add = 1'b1;
        if (stat_i.integ_go) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = cpid_pkg::MUL_ED;
          state_d       = ST_ISUM;
        end else begin
          state_d = ST_ILO;
        end
      end
      ST_ISUM: begin
        cmd_o.i_sum = 1'b1;
        state_d     = ST_ICLAMP;
      end
      ST_ICLAMP: begin
        cmd_o.i_clamp = 1'b1;
        state_d       = ST_ILO;
      end
      ST_ILO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpid_pkg::MUL_ILO;
        state_d       = ST_IHI;
      end
      ST_IHI: begin
        cmd_o.w_keep  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpid_pkg::MUL_IHI;
        state_d       = ST_ILOW;
      end
      ST_ILOW: begin
        cmd_o.i_low = 1'b1;
        state_d     = ST_IQ;
      end
      ST_IQ: begin
        cmd_o.i_quot = 1'b1;
        state_d      = ST_IACC;
      end
      ST_IACC: begin
        cmd_o.i_add = 1'b1;
        if (stat_i.dt_nz) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = cpid_pkg::MUL_DLO;
          state_d       = ST_DHI;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DHI: begin
        cmd_o.w_keep  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpid_pkg::MUL_DHI;
        state_d       = ST_DDIV;
      end
      ST_DDIV: begin
        cmd_o.d_start = 1'b1;
        state_d       = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.d_add = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/clamped_pid_with_dt_gating_core.sv
`timescale 1ns / 1ps
// top level of the clamped pid core with elapsed time gating
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    cmd_i, error_i, elapsed_us_i
//   out      output     out_valid_o / out_ready_i  drive_o, saturated_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one item at a time; a run step with a usable elapsed time updates the integral and waits on
// the divider for the derivative (no integral update with zero integral gain); one without a
// usable elapsed time skips both, a reset command or a zero output limit goes to the output;
// the shared 32x24 multiplier sets the order of the other steps
// reset clears controller state and loads the register defaults, no clearing pass
// the output register holds a finished item while the next one is accepted and worked on
module clamped_pid_with_dt_gating_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic signed [cpid_pkg::ERR_W-1:0]     error_i,
  input  logic [cpid_pkg::EL_W-1:0]             elapsed_us_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [cpid_pkg::ERR_W-1:0]     drive_o,
  output logic                                  saturated_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  cpid_pkg::cpid_cmd_t  ctl;
  cpid_pkg::cpid_stat_t stat;

  assign cfg_ready_o = 1'b1;

  cpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (ctl)
  );

  cpid_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_i),
    .error_i      (error_i),
    .elapsed_us_i (elapsed_us_i),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .drive_o      (drive_o),
    .saturated_o  (saturated_o)
  );

endmodule
